FILE: src/cdq_pkg.sv
// Package for the circular deque: default sizes, operation codes and the
// controller state type. No dependencies.
package cdq_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int WORD_BITS_DEF = 32;

   // Width of every word on the request and response ports.
   localparam int PORT_BITS = 32;

   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_REAR  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

endpackage

FILE: src/cdq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/circular_deque.sv
// Circular deque: push and pop at either end of a ring of DEPTH words.
// A push, a failed operation or a pop that empties the deque gives its
// response in the cycle after the transfer; any other pop first reads the
// ring RAM through its single registered read port in the read state, and no
// new request is taken until its response is loaded or while one is held.
// Synchronous reset empties the deque; the RAM contents are not cleared.
module circular_deque
   import cdq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int ADDR_BITS = $clog2(DEPTH),
   localparam int CNT_BITS  = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic signed [PORT_BITS-1:0] req_push_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic signed [PORT_BITS-1:0] rsp_pop_value,
   output logic                        rsp_is_empty,
   output logic [CNT_BITS-1:0]         rsp_occupancy,
   output logic signed [PORT_BITS-1:0] rsp_front_value
);

   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);
   localparam logic [ADDR_BITS-1:0] ONE_ADDR  = ADDR_BITS'(1);
   localparam logic [CNT_BITS-1:0]  FULL_CNT  = CNT_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0]  ONE_CNT   = CNT_BITS'(1);
   localparam logic signed [PORT_BITS-1:0] NONE_WORD = -PORT_BITS'(1);

   state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic signed [WORD_BITS-1:0] front_ff, front_in;
   logic pend_front_ff, pend_front_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff, rsp_ok_in;
   logic signed [PORT_BITS-1:0] rsp_pop_ff, rsp_pop_in;
   logic rsp_empty_ff, rsp_empty_in;
   logic [CNT_BITS-1:0] rsp_occ_ff, rsp_occ_in;
   logic signed [PORT_BITS-1:0] rsp_front_ff, rsp_front_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [ADDR_BITS-1:0]   ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_wr_data, ram_rd_data;

   logic accept, rsp_load;
   logic [ADDR_BITS-1:0] head_up, head_dn, tail_up, tail_dn;
   logic signed [WORD_BITS-1:0] push_word, rd_word;
   logic signed [PORT_BITS-1:0] front_port, rd_port, push_port, front_now;
   mode_type mode;

   cdq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign mode       = mode_type'(req_mode);
   assign head_up    = (head_ff == LAST_ADDR) ? '0 : head_ff + ONE_ADDR;
   assign head_dn    = (head_ff == '0) ? LAST_ADDR : head_ff - ONE_ADDR;
   assign tail_up    = (tail_ff == LAST_ADDR) ? '0 : tail_ff + ONE_ADDR;
   assign tail_dn    = (tail_ff == '0) ? LAST_ADDR : tail_ff - ONE_ADDR;
   assign push_word  = WORD_BITS'(req_push_value);
   assign rd_word    = ram_rd_data;
   assign front_port = PORT_BITS'(front_ff);
   assign rd_port    = PORT_BITS'(rd_word);
   assign push_port  = PORT_BITS'(push_word);
   assign front_now  = (count_ff == '0) ? NONE_WORD : front_port;

   // The response register must be free (or emptied this cycle) before a new
   // transfer, so a read started here always finds it free in the read state.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      pend_front_in = pend_front_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = tail_ff;
      ram_wr_data   = push_word;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head_up;
      rsp_load      = 1'b0;
      rsp_ok_in     = 1'b0;
      rsp_pop_in    = NONE_WORD;
      rsp_empty_in  = (count_ff == '0);
      rsp_occ_in    = count_ff;
      rsp_front_in  = front_now;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (mode)
                  MODE_PUSH_FRONT: begin
                     if (count_ff != FULL_CNT) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = head_dn;
                        head_in      = head_dn;
                        count_in     = count_ff + ONE_CNT;
                        front_in     = push_word;
                        rsp_ok_in    = 1'b1;
                        rsp_empty_in = 1'b0;
                        rsp_occ_in   = count_ff + ONE_CNT;
                        rsp_front_in = push_port;
                     end
                  end
                  MODE_PUSH_REAR: begin
                     if (count_ff != FULL_CNT) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = tail_ff;
                        tail_in      = tail_up;
                        count_in     = count_ff + ONE_CNT;
                        rsp_ok_in    = 1'b1;
                        rsp_empty_in = 1'b0;
                        rsp_occ_in   = count_ff + ONE_CNT;
                        if (count_ff == '0) begin
                           front_in     = push_word;
                           rsp_front_in = push_port;
                        end
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (count_ff != '0) begin
                        head_in  = head_up;
                        count_in = count_ff - ONE_CNT;
                        if (count_ff == ONE_CNT) begin
                           rsp_ok_in    = 1'b1;
                           rsp_pop_in   = front_port;
                           rsp_empty_in = 1'b1;
                           rsp_occ_in   = '0;
                           rsp_front_in = NONE_WORD;
                        end else begin
                           // The new front word has to come out of the RAM.
                           rsp_load      = 1'b0;
                           ram_rd_en     = 1'b1;
                           ram_rd_addr   = head_up;
                           pend_front_in = 1'b1;
                           state_in      = ST_READ;
                        end
                     end
                  end
                  MODE_POP_REAR: begin
                     if (count_ff != '0) begin
                        tail_in  = tail_dn;
                        count_in = count_ff - ONE_CNT;
                        if (count_ff == ONE_CNT) begin
                           // The only word is the front word as well.
                           rsp_ok_in    = 1'b1;
                           rsp_pop_in   = front_port;
                           rsp_empty_in = 1'b1;
                           rsp_occ_in   = '0;
                           rsp_front_in = NONE_WORD;
                        end else begin
                           rsp_load      = 1'b0;
                           ram_rd_en     = 1'b1;
                           ram_rd_addr   = tail_dn;
                           pend_front_in = 1'b0;
                           state_in      = ST_READ;
                        end
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            // Pops that reach this state leave at least one word behind.
            rsp_load     = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_empty_in = 1'b0;
            rsp_occ_in   = count_ff;
            if (pend_front_ff) begin
               front_in     = rd_word;
               rsp_pop_in   = front_port;
               rsp_front_in = rd_port;
            end else begin
               rsp_pop_in   = rd_port;
               rsp_front_in = front_port;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         pend_front_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         pend_front_ff <= pend_front_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      if (rsp_load) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_pop_ff   <= rsp_pop_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_occ_ff   <= rsp_occ_in;
         rsp_front_ff <= rsp_front_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_pop_value   = rsp_pop_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_occupancy   = rsp_occ_ff;
   assign rsp_front_value = rsp_front_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("deque count exceeds its depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty deque with head and tail apart");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("response register busy when read data returns");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("ring RAM written and read in one cycle");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (state_ff == ST_READ))
      else $error("RAM read issued without a read state after it");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque: a directed table and then random
// operations, checked against written results or an in-bench deque predictor. Uses cdq_pkg.
module testbench;
   import cdq_pkg::*;

   localparam int RING_DEPTH   = DEPTH_DEF;
   localparam int CNT_W        = $clog2(DEPTH_DEF + 1);
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int PHASE_OPS    = 450;
   localparam int DIRECTED_OPS = RING_DEPTH + 9;
   localparam int EXP_SLOTS    = 16;

   localparam logic signed [PORT_BITS-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [PORT_BITS-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [PORT_BITS-1:0] NO_WORD  = -32'sd1;

   typedef struct packed {
      logic                        ok;
      logic signed [PORT_BITS-1:0] pop_value;
      logic                        is_empty;
      logic [CNT_W-1:0]            occupancy;
      logic signed [PORT_BITS-1:0] front_value;
   } deque_result_type;

   typedef struct {
      mode_type                    mode;
      logic signed [PORT_BITS-1:0] value;
      bit                          typed;
      deque_result_type            want;
   } op_row_type;

   localparam deque_result_type NO_RESULT = '{1'b0, 32'sd0, 1'b0, 5'd0, 32'sd0};

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_mode = MODE_PUSH_FRONT;
   logic signed [PORT_BITS-1:0] req_push_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_ok;
   logic signed [PORT_BITS-1:0] rsp_pop_value;
   logic                        rsp_is_empty;
   logic [CNT_W-1:0]            rsp_occupancy;
   logic signed [PORT_BITS-1:0] rsp_front_value;

   circular_deque dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_front_value (rsp_front_value)
   );

   always #5 clock = ~clock;

   // Predictor state: a ring of words with front and rear pointers.
   logic signed [PORT_BITS-1:0] ring_words [RING_DEPTH];
   int                          front_idx = 0;
   int                          rear_idx = 0;
   int                          word_count = 0;

   // Expected responses in transfer order, kept in a small ring.
   deque_result_type expect_ring [EXP_SLOTS];
   int               exp_wr = 0;
   int               exp_rd = 0;
   deque_result_type oldest;
   int               errors = 0;
   int               checked = 0;
   int               refused = 0;
   int               full_seen = 0;
   int               cycle_count = 0;
   int               idle_pct = 0;
   int               stall_pct = 0;

   function automatic deque_result_type apply_deque_op(input mode_type m,
                                                       input logic signed [PORT_BITS-1:0] v);
      deque_result_type res;
      res.ok = 1'b0;
      res.pop_value = NO_WORD;
      if (m == MODE_PUSH_FRONT || m == MODE_PUSH_REAR) begin
         if (word_count < RING_DEPTH) begin
            if (m == MODE_PUSH_FRONT) begin
               front_idx = (front_idx == 0) ? RING_DEPTH - 1 : front_idx - 1;
               ring_words[front_idx] = v;
            end else begin
               ring_words[rear_idx] = v;
               rear_idx = (rear_idx == RING_DEPTH - 1) ? 0 : rear_idx + 1;
            end
            word_count++;
            res.ok = 1'b1;
         end
      end else if (word_count > 0) begin
         if (m == MODE_POP_FRONT) begin
            res.pop_value = ring_words[front_idx];
            front_idx = (front_idx == RING_DEPTH - 1) ? 0 : front_idx + 1;
         end else begin
            rear_idx = (rear_idx == 0) ? RING_DEPTH - 1 : rear_idx - 1;
            res.pop_value = ring_words[rear_idx];
         end
         word_count--;
         res.ok = 1'b1;
      end
      res.is_empty = (word_count == 0);
      res.occupancy = word_count[CNT_W-1:0];
      res.front_value = (word_count == 0) ? NO_WORD : ring_words[front_idx];
      return res;
   endfunction

   // Holds one operation on the request port until its transfer, then files
   // the expected response and, as idle_pct asks, may drop req_valid and idle.
   task automatic send_op(input mode_type m, input logic signed [PORT_BITS-1:0] v,
                          input bit typed, input deque_result_type typed_res);
      deque_result_type model_res;
      req_valid <= 1'b1;
      req_mode <= m;
      req_push_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_res = apply_deque_op(m, v);
      expect_ring[exp_wr % EXP_SLOTS] = typed ? typed_res : model_res;
      exp_wr++;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_rd == exp_wr) begin
            $error("response with no operation outstanding");
            errors++;
         end else begin
            oldest = expect_ring[exp_rd % EXP_SLOTS];
            exp_rd++;
            checked++;
            if (!rsp_ok) refused++;
            if (rsp_occupancy == RING_DEPTH) full_seen++;
            if (rsp_ok !== oldest.ok) begin
               $error("ok: expected %0d, got %0d", oldest.ok, rsp_ok);
               errors++;
            end
            if (rsp_pop_value !== oldest.pop_value) begin
               $error("pop_value: expected %0d, got %0d", oldest.pop_value, rsp_pop_value);
               errors++;
            end
            if (rsp_is_empty !== oldest.is_empty) begin
               $error("is_empty: expected %0d, got %0d", oldest.is_empty, rsp_is_empty);
               errors++;
            end
            if (rsp_occupancy !== oldest.occupancy) begin
               $error("occupancy: expected %0d, got %0d", oldest.occupancy, rsp_occupancy);
               errors++;
            end
            if (rsp_front_value !== oldest.front_value) begin
               $error("front_value: expected %0d, got %0d", oldest.front_value,
                      rsp_front_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      op_row_type                  directed_ops [DIRECTED_OPS];
      int                          row_count;
      op_row_type                  row;
      mode_type                    m;
      logic signed [PORT_BITS-1:0] v;
      int                          push_bias;

      // Empty pops, both word extremes through each end, then a fill past
      // full with pushes that wrap the front pointer below zero.
      row_count = 0;
      directed_ops[row_count++] = '{MODE_POP_FRONT, 32'sd0, 1'b1,
                                    '{1'b0, NO_WORD, 1'b1, 5'd0, NO_WORD}};
      directed_ops[row_count++] = '{MODE_POP_REAR, 32'sd0, 1'b1,
                                    '{1'b0, NO_WORD, 1'b1, 5'd0, NO_WORD}};
      directed_ops[row_count++] = '{MODE_PUSH_REAR, WORD_MAX, 1'b1,
                                    '{1'b1, NO_WORD, 1'b0, 5'd1, WORD_MAX}};
      directed_ops[row_count++] = '{MODE_PUSH_FRONT, WORD_MIN, 1'b1,
                                    '{1'b1, NO_WORD, 1'b0, 5'd2, WORD_MIN}};
      directed_ops[row_count++] = '{MODE_POP_FRONT, 32'sd0, 1'b1,
                                    '{1'b1, WORD_MIN, 1'b0, 5'd1, WORD_MAX}};
      directed_ops[row_count++] = '{MODE_POP_REAR, 32'sd0, 1'b1,
                                    '{1'b1, WORD_MAX, 1'b1, 5'd0, NO_WORD}};
      for (int i = 0; i < RING_DEPTH; i++) begin
         directed_ops[row_count++] = '{(i % 2 != 0) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
                                       (i == 0) ? NO_WORD : 32'sh9E37_79B9 * (i + 1),
                                       1'b0, NO_RESULT};
      end
      directed_ops[row_count++] = '{MODE_PUSH_REAR, 32'sh1234_5678, 1'b0, NO_RESULT};
      directed_ops[row_count++] = '{MODE_PUSH_FRONT, 32'sh0F0F_0F0F, 1'b0, NO_RESULT};
      directed_ops[row_count++] = '{MODE_POP_REAR, 32'sd0, 1'b0, NO_RESULT};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < row_count; i++) begin
         row = directed_ops[i];
         send_op(row.mode, row.value, row.typed, row.want);
      end

      // Random part in four phases of request idling and response stalling. The push
      // bias is redrawn every 32 operations so the deque swings between empty and full.
      push_bias = 50;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         for (int n = 0; n < PHASE_OPS; n++) begin
            if (n % 32 == 0) begin
               case ($urandom_range(2))
                  0: push_bias = 85;
                  1: push_bias = 50;
                  default: push_bias = 15;
               endcase
            end
            if ($urandom_range(99) < push_bias) begin
               m = $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            end else begin
               m = $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
            end
            case ($urandom_range(15))
               0: v = NO_WORD;
               1: v = WORD_MAX;
               2: v = WORD_MIN;
               3: v = 32'sd0;
               default: v = $urandom;
            endcase
            send_op(m, v, 1'b0, NO_RESULT);
         end
      end
      req_valid <= 1'b0;

      while (exp_rd != exp_wr) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("tb: %0d responses checked, %0d refused operations, %0d at full occupancy",
               checked, refused, full_seen);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
